>>> sv/rlcpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcpl_pkg
// Shared widths, codes and fixed constants of the cascaded position loop.
// ----------------------------------------------------------------------------
package rlcpl_pkg;

  // fixed field widths
  localparam int POS_W      = 24;
  localparam int DRIVE_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int STEP_W     = 12;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = 23;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // reciprocal scaling for the divide by tick rate
  localparam int RECIP_SHIFT = 25;

  // slew rates in Q16.8 per second
  localparam int UP_RATE       = 5 * 256;
  localparam int DOWN_RATE_LOW = 15 * 256;

  localparam logic signed [POS_W-1:0]   LOW_POS_LIMIT = 24'sd4096;
  localparam logic signed [POS_W-1:0]   CAL_VCMD      = -24'sd512;
  localparam logic signed [DRIVE_W-1:0] CAL_DRIVE_MAX = 16'sd4915;
  localparam logic signed [DRIVE_W-1:0] OVR_THRESH    = 16'sd6553;
  localparam logic signed [DRIVE_W-1:0] OVR_DRIVE     = 16'sd19661;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP             = 3'd0,
    REG_KFF            = 3'd1,
    REG_PROP_GAIN      = 3'd2,
    REG_INT_GAIN       = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_VELOCITY_LIMIT = 3'd5,
    REG_GOAL_ALLOWANCE = 3'd6,
    REG_TOP_HEIGHT     = 3'd7
  } cfg_idx_e;

endpackage
`default_nettype wire

>>> sv/rlcpl_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlcpl_mul
// Shared signed multiplier with a registered product, one product per cycle.
// ----------------------------------------------------------------------------
module rlcpl_mul (
  input  wire                                       clk_i,
  input  wire logic signed [rlcpl_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [rlcpl_pkg::MUL_B_W-1:0] b_i,
  output logic signed      [rlcpl_pkg::MUL_P_W-1:0] p_o
);
  import rlcpl_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;
  logic signed [MUL_P_W-1:0] p_d;

  assign p_d = MUL_P_W'(a_i) * MUL_P_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

>>> sv/rate_limited_cascade_position_loop.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rate_limited_cascade_position_loop
// Cascaded position and velocity PI loop with slew-limited command and
// start-up calibration, one control tick per input word.
// ----------------------------------------------------------------------------
// Each input word is one control tick and yields one output word. A loop tick
// runs through an idle state that accepts the word, fourteen sequencer steps
// that run every product (feedforward, velocity, position gain, the divide by
// the tick rate through a reciprocal, and both drive terms) through one shared
// 30 x 23 bit multiplier, and an output state that loads the output register.
// An override tick skips the loop: accept, front step and output load. The
// output load waits while the previous word still sits unaccepted in the
// output register, that is while m_axis_tready stays low. s_axis_tready is
// high only between ticks; a finished word waits in the output register while
// the next tick is accepted.
module rate_limited_cascade_position_loop #(
  parameter int TICKS_PER_SECOND = 50,
  parameter int CAL_TICKS        = 25
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  // configuration writes
  input  wire                                          cfg_we_i,
  input  wire logic [rlcpl_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [rlcpl_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // input stream
  input  wire                                          s_axis_tvalid,
  output logic                                         s_axis_tready,
  // position_raw, goal_value, override_cmd
  input  wire logic [63:0]                             s_axis_tdata,
  // goal_load, override_on, paused
  input  wire logic [2:0]                              s_axis_tuser,
  // output stream
  output logic                                         m_axis_tvalid,
  input  wire                                          m_axis_tready,
  // motor_drive
  output logic [15:0]                                  m_axis_tdata,
  // at_goal, calibrating
  output logic [1:0]                                   m_axis_tuser
);
  import rlcpl_pkg::*;

  localparam int UP_STEP   = (UP_RATE + TICKS_PER_SECOND / 2) / TICKS_PER_SECOND;
  localparam int DOWN_STEP = (DOWN_RATE_LOW + TICKS_PER_SECOND / 2) / TICKS_PER_SECOND;
  localparam int HALF_TPS  = TICKS_PER_SECOND / 2;
  localparam int RECIP     = (1 << RECIP_SHIFT) / TICKS_PER_SECOND;
  localparam int SR_W      = MUL_P_W + 1;

  localparam logic signed [MUL_B_W-1:0] TPS_B   = MUL_B_W'(TICKS_PER_SECOND);
  localparam logic signed [MUL_B_W-1:0] RECIP_B = MUL_B_W'(RECIP);
  localparam logic signed [SR_W-1:0]    V_MAX   = SR_W'(8388607);
  localparam logic signed [SR_W-1:0]    V_MIN   = -SR_W'(8388608);
  localparam logic signed [SR_W-1:0]    D_MAX   = SR_W'(32767);
  localparam logic signed [SR_W-1:0]    D_MIN   = -SR_W'(32768);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FRONT, ST_SLEW, ST_M_DT, ST_M_FF, ST_M_VEL, ST_M_ERR, ST_VCMD,
    ST_VERR, ST_D_MUL, ST_D_BACK, ST_D_FIX, ST_INTEG, ST_P_INT, ST_SUM, ST_OUT
  } state_e;

  function automatic logic signed [SR_W-1:0] shr_round(input logic signed [SR_W-1:0] x,
                                                       input int s);
    logic signed [SR_W-1:0] half;
    half = $signed(SR_W'(1) << (s - 1));
    if (x >= 0) begin
      return (x + half) >>> s;
    end
    return -((-x + half) >>> s);
  endfunction

  // configuration registers
  logic [GAIN_W-1:0]  kp_q, kff_q, pg_q, ig_q, allow_q;
  logic [LIMIT_W-1:0] ilim_q, vlim_q, top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= 16'd256;
      kff_q   <= 16'd0;
      pg_q    <= 16'd256;
      ig_q    <= 16'd256;
      ilim_q  <= 23'd65536;
      vlim_q  <= 23'd12800;
      allow_q <= 16'd128;
      top_q   <= 23'd6400;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_KP:             kp_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_KFF:            kff_q   <= cfg_wdata_i[GAIN_W-1:0];
        REG_PROP_GAIN:      pg_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_INT_GAIN:       ig_q    <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: ilim_q  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_VELOCITY_LIMIT: vlim_q  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_GOAL_ALLOWANCE: allow_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_TOP_HEIGHT:     top_q   <= cfg_wdata_i[LIMIT_W-1:0];
      endcase
    end
  end

  state_e state_q;

  // latched input word
  logic signed [POS_W-1:0]   raw_q, goal_val_q;
  logic signed [DRIVE_W-1:0] ovr_cmd_q;
  logic                      goal_load_q, ovr_on_q, paused_q;

  // loop state
  logic signed [POS_W-1:0] offset_q, sp_q, prev_pos_q, goal_q, integ_q, pos_q;
  logic                    cal_q;
  logic [15:0]             ticks_q;

  // working registers
  logic signed [STEP_W-1:0]  delta_q;
  logic signed [MUL_A_W-1:0] err_q;
  logic signed [POS_W-1:0]   vel_q, vcmd_q;
  logic signed [POS_W:0]     verr_q;
  logic [POS_W:0]            x_q;
  logic [21:0]               q_q;
  logic signed [MUL_P_W-1:0] acc_q;
  logic signed [DRIVE_W-1:0] drive_q;

  // output register
  logic              out_valid_q;
  logic [DRIVE_W-1:0] out_data_q;
  logic [1:0]        out_user_q;
  logic              out_load;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  rlcpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // front step
  logic signed [POS_W-1:0] pos_new, goal_sel, goal_clamped, top_ext;
  logic                    ticks_over, cal_fire, tick_inc;
  logic signed [DRIVE_W-1:0] ovr_drive;

  assign pos_new  = raw_q - offset_q;
  assign goal_sel = goal_load_q ? goal_val_q : goal_q;
  assign top_ext  = $signed({1'b0, top_q});

  always_comb begin
    if (goal_sel < 0) begin
      goal_clamped = '0;
    end else if (goal_sel > top_ext) begin
      goal_clamped = top_ext;
    end else begin
      goal_clamped = goal_sel;
    end
    if (ovr_cmd_q > OVR_THRESH) begin
      ovr_drive = OVR_DRIVE;
    end else if (ovr_cmd_q < -OVR_THRESH) begin
      ovr_drive = -OVR_DRIVE;
    end else begin
      ovr_drive = '0;
    end
  end

  assign ticks_over = {1'b0, ticks_q} > 17'(CAL_TICKS);
  assign cal_fire   = ticks_over && (pos_new == prev_pos_q) && cal_q;
  assign tick_inc   = !ticks_over && (ticks_q != '1);

  // slew step
  logic signed [POS_W:0] sp_diff, up_lim, down_lim, delta_full;

  assign sp_diff  = (POS_W + 1)'(goal_q) - (POS_W + 1)'(sp_q);
  assign up_lim   = (POS_W + 1)'(UP_STEP);
  assign down_lim = (pos_q < LOW_POS_LIMIT) ? (POS_W + 1)'(DOWN_STEP)
                                            : (POS_W + 1)'(UP_STEP);

  always_comb begin
    if (sp_diff > up_lim) begin
      delta_full = up_lim;
    end else if (sp_diff < -down_lim) begin
      delta_full = -down_lim;
    end else begin
      delta_full = sp_diff;
    end
  end

  // distance to goal
  logic signed [POS_W:0] dist_s;
  logic [POS_W:0]        dist_abs;
  logic                  near_goal;

  assign dist_s    = (POS_W + 1)'(goal_q) - (POS_W + 1)'(pos_q);
  assign dist_abs  = dist_s[POS_W] ? (POS_W + 1)'(-dist_s) : (POS_W + 1)'(dist_s);
  assign near_goal = dist_abs <= {{(POS_W + 1 - GAIN_W){1'b0}}, allow_q};

  // scaled products
  logic signed [SR_W-1:0]    prod_ext, prod_r8, sum_r1;
  logic signed [MUL_P_W-1:0] vlim_ext;
  logic signed [POS_W-1:0]   vel_clamped, vcmd_gain;

  assign prod_ext = SR_W'(prod);
  assign prod_r8  = shr_round(prod_ext, 8);
  assign vlim_ext = $signed({{(MUL_P_W - LIMIT_W){1'b0}}, vlim_q});

  always_comb begin
    if (prod > vlim_ext) begin
      vel_clamped = POS_W'(vlim_ext);
    end else if (prod < -vlim_ext) begin
      vel_clamped = POS_W'(-vlim_ext);
    end else begin
      vel_clamped = POS_W'(prod);
    end
    if (prod_r8 > V_MAX) begin
      vcmd_gain = POS_W'(V_MAX);
    end else if (prod_r8 < V_MIN) begin
      vcmd_gain = POS_W'(V_MIN);
    end else begin
      vcmd_gain = POS_W'(prod_r8);
    end
  end

  // divide by tick rate
  logic [POS_W:0]          verr_abs, x_new;
  logic signed [POS_W+1:0] rem;
  logic signed [POS_W-1:0] q_signed;
  logic signed [POS_W+1:0] integ_sum, ilim_ext;
  logic signed [POS_W-1:0] integ_new;

  assign verr_abs = verr_q[POS_W] ? (POS_W + 1)'(-verr_q) : (POS_W + 1)'(verr_q);
  assign x_new    = verr_abs + (POS_W + 1)'(HALF_TPS);
  assign rem      = $signed({1'b0, x_q}) - (POS_W + 2)'(prod);
  assign q_signed = verr_q[POS_W] ? -$signed({2'b0, q_q}) : $signed({2'b0, q_q});
  assign integ_sum = (POS_W + 2)'(integ_q) + (POS_W + 2)'(q_signed);
  assign ilim_ext  = $signed({3'b0, ilim_q});

  always_comb begin
    if (integ_sum > ilim_ext) begin
      integ_new = POS_W'(ilim_ext);
    end else if (integ_sum < -ilim_ext) begin
      integ_new = POS_W'(-ilim_ext);
    end else begin
      integ_new = POS_W'(integ_sum);
    end
  end

  // drive sum
  logic signed [SR_W-1:0]    drive_full;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign sum_r1 = shr_round(SR_W'(acc_q) + prod_ext, 1);

  always_comb begin
    if (sum_r1 > D_MAX) begin
      drive_full = D_MAX;
    end else if (sum_r1 < D_MIN) begin
      drive_full = D_MIN;
    end else begin
      drive_full = sum_r1;
    end
    drive_sat = DRIVE_W'(drive_full);
    if (cal_q) begin
      if (drive_sat > CAL_DRIVE_MAX) begin
        drive_sat = CAL_DRIVE_MAX;
      end else if (drive_sat < -CAL_DRIVE_MAX) begin
        drive_sat = -CAL_DRIVE_MAX;
      end
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_M_DT: begin
        mul_a = MUL_A_W'(delta_q);
        mul_b = TPS_B;
      end
      ST_M_FF: begin
        mul_a = $signed(prod[MUL_A_W-1:0]);
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, kff_q});
      end
      ST_M_VEL: begin
        mul_a = MUL_A_W'(pos_q) - MUL_A_W'(prev_pos_q);
        mul_b = TPS_B;
      end
      ST_M_ERR: begin
        mul_a = err_q;
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, kp_q});
      end
      ST_D_MUL: begin
        mul_a = $signed({{(MUL_A_W - POS_W - 1){1'b0}}, x_new});
        mul_b = RECIP_B;
      end
      ST_D_BACK: begin
        mul_a = $signed({{(MUL_A_W - 22){1'b0}}, prod[RECIP_SHIFT+21:RECIP_SHIFT]});
        mul_b = TPS_B;
      end
      ST_INTEG: begin
        mul_a = MUL_A_W'(verr_q);
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, pg_q});
      end
      ST_P_INT: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = $signed({{(MUL_B_W - GAIN_W){1'b0}}, ig_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      raw_q       <= '0;
      goal_val_q  <= '0;
      ovr_cmd_q   <= '0;
      goal_load_q <= 1'b0;
      ovr_on_q    <= 1'b0;
      paused_q    <= 1'b0;
      offset_q    <= '0;
      sp_q        <= '0;
      prev_pos_q  <= '0;
      goal_q      <= '0;
      integ_q     <= '0;
      pos_q       <= '0;
      cal_q       <= 1'b1;
      ticks_q     <= '0;
      delta_q     <= '0;
      err_q       <= '0;
      vel_q       <= '0;
      vcmd_q      <= '0;
      verr_q      <= '0;
      x_q         <= '0;
      q_q         <= '0;
      acc_q       <= '0;
      drive_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            raw_q       <= $signed(s_axis_tdata[23:0]);
            goal_val_q  <= $signed(s_axis_tdata[47:24]);
            ovr_cmd_q   <= $signed(s_axis_tdata[63:48]);
            goal_load_q <= s_axis_tuser[0];
            ovr_on_q    <= s_axis_tuser[1];
            paused_q    <= s_axis_tuser[2];
            state_q     <= ST_FRONT;
          end
        end
        ST_FRONT: begin
          if (ovr_on_q) begin
            pos_q   <= pos_new;
            goal_q  <= goal_clamped;
            drive_q <= ovr_drive;
            state_q <= ST_OUT;
          end else begin
            if (cal_fire) begin
              offset_q   <= raw_q;
              pos_q      <= '0;
              sp_q       <= '0;
              prev_pos_q <= '0;
              goal_q     <= '0;
              integ_q    <= '0;
              cal_q      <= 1'b0;
            end else begin
              pos_q  <= pos_new;
              goal_q <= goal_clamped;
              if (tick_inc) begin
                ticks_q <= ticks_q + 16'd1;
              end
            end
            state_q <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          delta_q <= STEP_W'(delta_full);
          sp_q    <= sp_q + POS_W'(delta_full);
          state_q <= ST_M_DT;
        end
        ST_M_DT: begin
          state_q <= ST_M_FF;
        end
        ST_M_FF: begin
          state_q <= ST_M_VEL;
        end
        ST_M_VEL: begin
          err_q   <= MUL_A_W'(sp_q) + MUL_A_W'(prod_r8) - MUL_A_W'(pos_q);
          state_q <= ST_M_ERR;
        end
        ST_M_ERR: begin
          vel_q   <= vel_clamped;
          state_q <= ST_VCMD;
        end
        ST_VCMD: begin
          if (cal_q) begin
            vcmd_q <= CAL_VCMD;
          end else if (near_goal) begin
            vcmd_q <= '0;
          end else begin
            vcmd_q <= vcmd_gain;
          end
          state_q <= ST_VERR;
        end
        ST_VERR: begin
          verr_q  <= (POS_W + 1)'(vcmd_q) - (POS_W + 1)'(vel_q);
          state_q <= ST_D_MUL;
        end
        ST_D_MUL: begin
          x_q     <= x_new;
          state_q <= ST_D_BACK;
        end
        ST_D_BACK: begin
          q_q     <= prod[RECIP_SHIFT+21:RECIP_SHIFT];
          state_q <= ST_D_FIX;
        end
        ST_D_FIX: begin
          if (rem >= (POS_W + 2)'(TICKS_PER_SECOND)) begin
            q_q <= q_q + 22'd1;
          end
          state_q <= ST_INTEG;
        end
        ST_INTEG: begin
          integ_q <= integ_new;
          state_q <= ST_P_INT;
        end
        ST_P_INT: begin
          acc_q   <= prod;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          drive_q    <= drive_sat;
          prev_pos_q <= pos_q;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_q    <= (paused_q && !cal_q) ? '0 : drive_q;
            out_user_q[0] <= !cal_q && near_goal;
            out_user_q[1] <= cal_q;
            state_q       <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a tick is in progress");

  a_cal_never_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cal_q |=> !cal_q)
    else $error("calibration restarted");

  a_setpoint_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sp_q[POS_W-1])
    else $error("setpoint went negative");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("output word loaded outside the output step");

endmodule
`default_nettype wire

>>> verif/tb_rate_limited_cascade_position_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rate_limited_cascade_position_loop
// Drives control ticks into the cascaded position loop with random gaps on
// both streams, predicts every output word with an independent fixed-point
// model of the loop, and compares each field. It covers start-up
// calibration, goal clamping, at-goal edges, override and pause, position
// wrap, and random runs under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_rate_limited_cascade_position_loop;
  import rlcpl_pkg::*;

  localparam int     CLK_PERIOD       = 8;
  localparam int     TICKS_PER_SECOND = 50;
  localparam int     CAL_TICKS        = 25;
  localparam int     PHASE_TICKS      = 250;
  localparam int     IDLE_WAIT        = 24;
  localparam int     CYCLE_LIMIT      = 3000000;
  localparam longint P24_MAX          = 8388607;
  localparam longint P24_MIN          = -8388608;
  localparam longint SLEW_UP          = 5 * 256;
  localparam longint SLEW_DOWN_LOW    = 15 * 256;
  localparam longint LOW_ZONE         = 16 * 256;
  localparam longint CAL_DEMAND       = -512;
  localparam longint CAL_DRIVE_CAP    = 4915;
  localparam longint STICK_DEADBAND   = 6553;
  localparam longint STICK_DRIVE      = 19661;

  typedef struct packed {
    logic signed [23:0] position_raw;
    logic               goal_load;
    logic signed [23:0] goal_value;
    logic               override_on;
    logic signed [15:0] override_cmd;
    logic               paused;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] motor_drive;
    logic               at_goal;
    logic               calibrating;
  } drive_t;

  typedef enum {SET_TYPICAL, SET_HIGH, SET_ZERO, SET_MIXED, SET_RESET} setting_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  cfg_idx_e              cfg_idx   = REG_KP;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_valid   = 1'b0;
  logic [63:0]           s_tdata   = '0;
  logic [2:0]            s_tuser   = '0;
  logic                  m_ready   = 1'b0;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [15:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  // loop model state and registers
  longint g_kp = 256, g_kff = 0, g_prop = 256, g_int = 256;
  longint lim_int = 65536, lim_vel = 12800, allowance = 128, top_h = 6400;
  longint ofs = 0, sp = 0, sp_prev = 0, pos_prev = 0, goal = 0, integ = 0;
  bit     cal_on = 1'b1;
  int     cal_cnt = 0;

  drive_t      drive_q[$];
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          send_burst = 0;
  longint      hold_pos = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  rate_limited_cascade_position_loop #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND),
    .CAL_TICKS       (CAL_TICKS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint wrap24(longint v);
    logic signed [23:0] w;
    w = v[23:0];
    return longint'(w);
  endfunction

  function automatic longint round_shift(longint x, int s);
    longint half;
    half = longint'(1) <<< (s - 1);
    if (x >= 0) return (x + half) >>> s;
    return -((-x + half) >>> s);
  endfunction

  function automatic longint div_rate(longint x);
    if (x >= 0) return (x + TICKS_PER_SECOND / 2) / TICKS_PER_SECOND;
    return -((-x + TICKS_PER_SECOND / 2) / TICKS_PER_SECOND);
  endfunction

  function automatic longint span(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // one control tick of the loop, updates the model state
  function automatic drive_t control_tick(tick_t t);
    longint raw, pos, drive, up, down, ff, err, vel, vcmd, verr, oc;
    drive_t r;
    raw   = t.position_raw;
    pos   = wrap24(raw - ofs);
    drive = 0;
    if (t.goal_load) goal = t.goal_value;
    goal = sat(goal, 0, top_h);
    if (t.override_on) begin
      oc = t.override_cmd;
      drive = (oc > STICK_DEADBAND) ? STICK_DRIVE : ((oc < -STICK_DEADBAND) ? -STICK_DRIVE : 0);
    end else begin
      if (cal_cnt > CAL_TICKS) begin
        if (pos == pos_prev && cal_on) begin
          cal_on   = 1'b0;
          ofs      = raw;
          pos      = 0;
          sp       = 0;
          sp_prev  = 0;
          pos_prev = 0;
          goal     = 0;
          integ    = 0;
        end
      end else if (cal_cnt < 65535) begin
        cal_cnt++;
      end
      up   = div_rate(SLEW_UP);
      down = (pos < LOW_ZONE) ? div_rate(SLEW_DOWN_LOW) : div_rate(SLEW_UP);
      sp   = sp + sat(goal - sp, -down, up);
      ff   = round_shift(g_kff * (sp - sp_prev) * TICKS_PER_SECOND, 8);
      err  = sp + ff - pos;
      vel  = sat((pos - pos_prev) * TICKS_PER_SECOND, -lim_vel, lim_vel);
      if (cal_on) vcmd = CAL_DEMAND;
      else if (span(goal, pos) <= allowance) vcmd = 0;
      else vcmd = sat(round_shift(g_kp * err, 8), P24_MIN, P24_MAX);
      verr  = vcmd - vel;
      integ = sat(integ + div_rate(verr), -lim_int, lim_int);
      drive = round_shift(g_prop * verr + g_int * integ, 1);
      if (cal_on) drive = sat(drive, -CAL_DRIVE_CAP, CAL_DRIVE_CAP);
      pos_prev = pos;
      sp_prev  = sp;
    end
    drive = sat(drive, -32768, 32767);
    if (t.paused && !cal_on) drive = 0;
    r.motor_drive = drive[15:0];
    r.at_goal     = !cal_on && (span(goal, pos) <= allowance);
    r.calibrating = cal_on;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 90);
  endfunction

  function automatic logic [23:0] raw_at(longint p);
    longint v;
    v = ofs + p;
    return v[23:0];
  endfunction

  function automatic tick_t mk_tick(logic [23:0] raw, bit gl, longint gv, bit ov,
                                    longint oc, bit pz);
    tick_t t;
    t.position_raw = raw;
    t.goal_load    = gl;
    t.goal_value   = gv[23:0];
    t.override_on  = ov;
    t.override_cmd = oc[15:0];
    t.paused       = pz;
    return t;
  endfunction

  // position follows the command, stands still or jumps, goals now and then
  function automatic tick_t plausible_tick();
    tick_t  t;
    int     r;
    longint gv;
    r = $urandom_range(0, 9);
    if (r < 3) hold_pos = hold_pos;
    else if (r < 7) hold_pos = sp + longint'($urandom_range(0, 64)) - 32;
    else if (r < 9) hold_pos = goal + longint'($urandom_range(0, 600)) - 300;
    else hold_pos = hold_pos + longint'($urandom_range(0, 4000)) - 2000;
    if ($urandom_range(0, 9) == 0) gv = -longint'($urandom_range(1, 100000));
    else gv = longint'($urandom_range(0, int'(top_h) + 512));
    t = mk_tick(raw_at(hold_pos), $urandom_range(0, 9) == 0, gv,
                $urandom_range(0, 19) == 0, longint'($urandom), $urandom_range(0, 19) == 0);
    return t;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.position_raw = 24'($urandom);
    t.goal_load    = 1'($urandom_range(0, 1));
    t.goal_value   = 24'($urandom);
    t.override_on  = 1'($urandom_range(0, 1));
    t.override_cmd = 16'($urandom);
    t.paused       = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(cfg_idx_e idx, setting_e mode);
    logic [CFG_DATA_W-1:0] full;
    if (idx == REG_INTEGRAL_LIMIT || idx == REG_VELOCITY_LIMIT || idx == REG_TOP_HEIGHT)
      full = 23'h7FFFFF;
    else
      full = 23'h00FFFF;
    case (mode)
      SET_HIGH: return full;
      SET_ZERO: return '0;
      SET_MIXED: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return full;
          default: return CFG_DATA_W'($urandom) & full;
        endcase
      end
      SET_RESET: begin
        case (idx)
          REG_KP, REG_PROP_GAIN, REG_INT_GAIN: return 256;
          REG_KFF:            return 0;
          REG_INTEGRAL_LIMIT: return 65536;
          REG_VELOCITY_LIMIT: return 12800;
          REG_GOAL_ALLOWANCE: return 128;
          default:            return 6400;
        endcase
      end
      default: begin
        case (idx)
          REG_KP:             return CFG_DATA_W'($urandom_range(64, 2048));
          REG_KFF:            return CFG_DATA_W'($urandom_range(0, 512));
          REG_PROP_GAIN:      return CFG_DATA_W'($urandom_range(64, 4096));
          REG_INT_GAIN:       return CFG_DATA_W'($urandom_range(0, 1024));
          REG_INTEGRAL_LIMIT: return CFG_DATA_W'($urandom_range(0, 200000));
          REG_VELOCITY_LIMIT: return CFG_DATA_W'($urandom_range(0, 60000));
          REG_GOAL_ALLOWANCE: return CFG_DATA_W'($urandom_range(0, 600));
          default:            return CFG_DATA_W'($urandom_range(256, 30000));
        endcase
      end
    endcase
  endfunction

  // sends one tick word, called at a falling edge, returns at a falling edge
  task automatic send_tick(input tick_t t);
    int gap;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) send_burst = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_tdata <= {t.override_cmd, t.goal_value, t.position_raw};
    s_tuser <= {t.paused, t.override_on, t.goal_load};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    drive_q.push_back(control_tick(t));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_KP:             g_kp      = val[15:0];
      REG_KFF:            g_kff     = val[15:0];
      REG_PROP_GAIN:      g_prop    = val[15:0];
      REG_INT_GAIN:       g_int     = val[15:0];
      REG_INTEGRAL_LIMIT: lim_int   = val[22:0];
      REG_VELOCITY_LIMIT: lim_vel   = val[22:0];
      REG_GOAL_ALLOWANCE: allowance = val[15:0];
      default:            top_h     = val[22:0];
    endcase
  endtask

  task automatic test_calibration();
    logic [23:0] base;
    longint      step;
    base = 24'($urandom);
    send_tick(mk_tick(24'h7FFFFF, 1, P24_MAX, 0, 0, 0));
    send_tick(mk_tick(24'h800000, 1, P24_MIN, 0, 0, 0));
    send_tick(mk_tick(24'h000000, 0, 0, 1, 32767, 0));
    send_tick(mk_tick(24'h000000, 0, 0, 1, -32768, 1));
    send_tick(mk_tick(24'd1000, 0, 0, 0, 0, 1));
    send_tick(mk_tick(base, 1, 3000, 1, 6554, 0));
    send_tick(mk_tick(base, 0, 0, 0, 0, 0));
    // still moving while the tick count runs out
    while (cal_cnt <= CAL_TICKS) begin
      step = longint'($urandom_range(0, 600)) - 300;
      send_tick(mk_tick(base + step[23:0], $urandom_range(0, 3) == 0, $urandom,
                        $urandom_range(0, 9) == 0, $urandom, $urandom_range(0, 4) == 0));
    end
    send_tick(mk_tick(base + 24'd10, 0, 0, 0, 0, 0));
    send_tick(mk_tick(base + 24'd20, 0, 0, 0, 0, 0));
    while (cal_on) send_tick(mk_tick(base + 24'd20, 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_loop_cases();
    send_tick(mk_tick(raw_at(0), 1, P24_MAX, 0, 0, 0));
    send_tick(mk_tick(raw_at(0), 1, P24_MIN, 0, 0, 0));
    send_tick(mk_tick(raw_at(0), 1, 3000, 0, 0, 0));
    // at-goal window edges
    send_tick(mk_tick(raw_at(3000 - 128), 0, 0, 0, 0, 0));
    send_tick(mk_tick(raw_at(3000 - 129), 0, 0, 0, 0, 0));
    send_tick(mk_tick(raw_at(3000 + 128), 0, 0, 0, 0, 0));
    send_tick(mk_tick(raw_at(3000 + 129), 0, 0, 0, 0, 0));
    send_tick(mk_tick(24'h7FFFFF, 0, 0, 0, 0, 0));
    send_tick(mk_tick(24'h800000, 0, 0, 0, 0, 0));
    // override stick thresholds
    send_tick(mk_tick(raw_at(3000), 0, 0, 1, 32767, 0));
    send_tick(mk_tick(raw_at(3000), 0, 0, 1, -32768, 0));
    send_tick(mk_tick(raw_at(3000), 0, 0, 1, 6553, 0));
    send_tick(mk_tick(raw_at(3000), 0, 0, 1, 6554, 0));
    send_tick(mk_tick(raw_at(3000), 0, 0, 1, -6553, 0));
    send_tick(mk_tick(raw_at(3000), 1, 500, 1, -6554, 1));
    send_tick(mk_tick(raw_at(1000), 0, 0, 0, 0, 1));
    // slow descent above the low zone, fast below it
    send_tick(mk_tick(raw_at(5000), 1, 100, 0, 0, 0));
    send_tick(mk_tick(raw_at(100), 0, 0, 0, 0, 0));
    send_tick(mk_tick(raw_at(100), 0, 0, 0, 0, 0));
    wait_idle();
  endtask

  task automatic test_register_settings();
    setting_e mode;
    for (int p = 0; p < 8; p++) begin
      case (p)
        1:       mode = SET_HIGH;
        3:       mode = SET_ZERO;
        4, 6:    mode = SET_MIXED;
        7:       mode = SET_RESET;
        default: mode = SET_TYPICAL;
      endcase
      for (int i = 0; i < 8; i++) write_reg(cfg_idx_e'(i), pick_reg(cfg_idx_e'(i), mode));
      for (int n = 0; n < PHASE_TICKS; n++)
        send_tick(($urandom_range(0, 99) < 85) ? plausible_tick() : noise_tick());
      wait_idle();
    end
  endtask

  // output side pacing
  initial begin : rx_pace
    int run, gap;
    @(negedge clk);
    forever begin
      m_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8);
      repeat (run) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_words
    drive_t want;
    if (rst_n && m_axis_tvalid && m_ready) begin
      if (drive_q.size() == 0) begin
        $error("output word with nothing expected: motor_drive %0d", $signed(m_axis_tdata));
        err_cnt++;
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata !== want.motor_drive) begin
          $error("motor_drive mismatch: expected %0d, got %0d", want.motor_drive,
                 $signed(m_axis_tdata));
          err_cnt++;
        end
        if (m_axis_tuser[0] !== want.at_goal) begin
          $error("at_goal mismatch: expected %0d, got %0d", want.at_goal, m_axis_tuser[0]);
          err_cnt++;
        end
        if (m_axis_tuser[1] !== want.calibrating) begin
          $error("calibrating mismatch: expected %0d, got %0d", want.calibrating,
                 m_axis_tuser[1]);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("FAIL rate_limited_cascade_position_loop");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_calibration();
    test_loop_cases();
    test_register_settings();
    repeat (IDLE_WAIT) @(negedge clk);
    if (err_cnt == 0) begin
      $display("PASS rate_limited_cascade_position_loop");
    end else begin
      $display("FAIL rate_limited_cascade_position_loop");
    end
    $finish;
  end

endmodule
